[src/jsu_pkg.sv]
// shared types, constants and decode helpers for the json string unescaper
package jsu_pkg;

  // parse modes of the escape decoder
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESCAPE  = 3'd1,
    MODE_HEX1    = 3'd2,
    MODE_HEX2    = 3'd3,
    MODE_HEX3    = 3'd4,
    MODE_HEX4    = 3'd5,
    MODE_DISCARD = 3'd6
  } mode_t;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned ACCUM_W     = 12;
  localparam int unsigned CODE_W      = 16;

  // special input bytes
  localparam logic [7:0] CHR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHR_QUOTE     = 8'h22;
  localparam logic [7:0] CHR_SLASH     = 8'h2f;
  localparam logic [7:0] CHR_N         = 8'h6e;
  localparam logic [7:0] CHR_T         = 8'h74;
  localparam logic [7:0] CHR_R         = 8'h72;
  localparam logic [7:0] CHR_B         = 8'h62;
  localparam logic [7:0] CHR_F         = 8'h66;
  localparam logic [7:0] CHR_U         = 8'h75;

  // utf-8 encoding constants
  localparam logic [CODE_W-1:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [CODE_W-1:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [7:0]        UTF8_LEAD2     = 8'hc0;
  localparam logic [7:0]        UTF8_LEAD3     = 8'he0;
  localparam logic [7:0]        UTF8_CONT      = 8'h80;

  // up to three results produced by one input byte, first in bytes[0]
  typedef struct packed {
    logic [1:0]                   count;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
    logic                         byte_valid;
    logic                         error;
    logic                         last;
  } bundle_t;

  // lowercase hex digit value; bit 4 set means not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  // single-character escapes; bit 8 set means known escape
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] v;
    case (c)
      CHR_QUOTE:     v = {1'b1, 8'h22};
      CHR_BACKSLASH: v = {1'b1, 8'h5c};
      CHR_SLASH:     v = {1'b1, 8'h2f};
      CHR_N:         v = {1'b1, 8'h0a};
      CHR_T:         v = {1'b1, 8'h09};
      CHR_R:         v = {1'b1, 8'h0d};
      CHR_B:         v = {1'b1, 8'h08};
      CHR_F:         v = {1'b1, 8'h0c};
      default:       v = 9'h000;
    endcase
    return v;
  endfunction

endpackage

[src/jsu_decoder.sv]
// escape decoder: parse state and combinational mapping of one byte to a result bundle
module jsu_decoder import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output bundle_t    bundle
);

  mode_t                mode, mode_next;
  logic [ACCUM_W-1:0]   code_accum, code_accum_next;
  logic [4:0]           hex;
  logic [8:0]           esc;
  logic [CODE_W-1:0]    cp;

  assign hex = hex_digit(in_byte);
  assign esc = simple_escape(in_byte);
  assign cp  = {code_accum, hex[3:0]};

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      code_accum <= '0;
    end else if (advance) begin
      mode       <= mode_next;
      code_accum <= code_accum_next;
    end
  end

  // next parse mode and code accumulator
  always_comb begin
    mode_next       = mode;
    code_accum_next = code_accum;
    unique case (mode) inside
      MODE_NORMAL: begin
        if (in_byte == CHR_BACKSLASH) begin
          mode_next = in_last ? MODE_NORMAL : MODE_ESCAPE;
        end
      end
      MODE_ESCAPE: begin
        if (in_byte == CHR_U) begin
          mode_next       = in_last ? MODE_NORMAL : MODE_HEX1;
          code_accum_next = '0;
        end else if (esc[8]) begin
          mode_next = MODE_NORMAL;
        end else begin
          mode_next       = in_last ? MODE_NORMAL : MODE_DISCARD;
          code_accum_next = '0;
        end
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
        if (hex[4] || mode == MODE_HEX4 || in_last) begin
          code_accum_next = '0;
          if (hex[4] && !in_last) begin
            mode_next = MODE_DISCARD;
          end else begin
            mode_next = MODE_NORMAL;
          end
        end else begin
          code_accum_next = {code_accum[ACCUM_W-5:0], hex[3:0]};
          mode_next       = mode_t'(mode + 3'd1);
        end
      end
      default: begin
        if (in_last) begin
          mode_next       = MODE_NORMAL;
          code_accum_next = '0;
        end else begin
          mode_next = MODE_DISCARD;
        end
      end
    endcase
  end

  // result bundle for the current byte
  always_comb begin
    bundle = '0;
    unique case (mode) inside
      MODE_NORMAL: begin
        if (in_byte == CHR_BACKSLASH) begin
          if (in_last) begin
            bundle.count = 2'd1;
            bundle.error = 1'b1;
            bundle.last  = 1'b1;
          end
        end else begin
          bundle.count      = 2'd1;
          bundle.bytes[0]   = in_byte;
          bundle.byte_valid = 1'b1;
          bundle.last       = in_last;
        end
      end
      MODE_ESCAPE: begin
        if (in_byte == CHR_U) begin
          if (in_last) begin
            bundle.count = 2'd1;
            bundle.error = 1'b1;
            bundle.last  = 1'b1;
          end
        end else if (esc[8]) begin
          bundle.count      = 2'd1;
          bundle.bytes[0]   = esc[7:0];
          bundle.byte_valid = 1'b1;
          bundle.last       = in_last;
        end else begin
          bundle.count = 2'd1;
          bundle.error = 1'b1;
          bundle.last  = in_last;
        end
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
        if (hex[4] || (mode != MODE_HEX4 && in_last)) begin
          // bad digit, or string ends before the fourth digit
          bundle.count = 2'd1;
          bundle.error = 1'b1;
          bundle.last  = in_last;
        end else if (mode == MODE_HEX4) begin
          bundle.byte_valid = 1'b1;
          bundle.last       = in_last;
          if (cp < ONE_BYTE_LIMIT) begin
            bundle.count    = 2'd1;
            bundle.bytes[0] = cp[7:0];
          end else if (cp < TWO_BYTE_LIMIT) begin
            bundle.count    = 2'd2;
            bundle.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
            bundle.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
          end else begin
            bundle.count    = 2'd3;
            bundle.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
            bundle.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
            bundle.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
          end
        end
      end
      default: begin
        // discarding: only the final byte closes the string
        if (in_last) begin
          bundle.count = 2'd1;
          bundle.last  = 1'b1;
        end
      end
    endcase
  end

endmodule

[src/jsu_serializer.sv]
// result register that hands a bundle out one transaction at a time
module jsu_serializer import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  bundle_t    bundle,
  output logic       load_ready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] byte_valid, [1] error
  output logic       m_tlast,   // out_last
  output logic       m_tvalid,
  input  logic       m_tready
);

  bundle_t    held;
  logic [1:0] count;
  logic [1:0] pos;
  logic [1:0] last_pos;
  logic       at_end;
  logic       take;

  assign last_pos   = count - 2'd1;
  assign at_end     = (pos == last_pos);
  assign take       = m_tvalid && m_tready;
  assign load_ready = (count == 2'd0) || (take && at_end);

  // count of results held; zero means empty
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
    end else if (load) begin
      count <= bundle.count;
      pos   <= '0;
    end else if (take) begin
      if (at_end) begin
        count <= '0;
      end
      pos <= pos + 2'd1;
    end
  end

  // bundle payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

  // current result
  assign m_tvalid   = (count != 2'd0);
  assign m_tdata    = held.bytes[pos];
  assign m_tuser[0] = held.byte_valid;
  assign m_tuser[1] = held.error;
  assign m_tlast    = held.last && at_end;

endmodule

[src/json_string_unescaper_unit.sv]
// top level of the json string unescaper: input register, decoder, result serializer
//
//  channel | direction | tdata      | tuser                     | tlast
//  s_*     | in        | [7:0] byte | -                         | final byte of string
//  m_*     | out       | [7:0] byte | [0] byte_valid, [1] error | final result of string
//
// while m_tready is high, a byte giving zero or one result is accepted every cycle;
// a \u escape of k utf-8 bytes holds the result register until all k bytes are taken
// a byte is registered in the input register, then decoded into the result register
// rst is synchronous; parse state returns to normal, both stages empty
// stalls on m_tready back up through the result register into s_tready
module json_string_unescaper_unit import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] byte_valid, [1] error
  output logic       m_tlast,   // out_last
  output logic       m_tvalid,
  input  logic       m_tready
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       load_ready;
  logic       advance;
  bundle_t    bundle;

  assign advance  = in_full && load_ready;
  assign s_tready = !in_full || advance;

  // input register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  jsu_decoder u_decoder (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (in_byte),
    .in_last (in_last),
    .bundle  (bundle)
  );

  jsu_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .bundle     (bundle),
    .load_ready (load_ready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready)
  );

endmodule

[src/jsu_checker.sv]
// port-level checks on the unescaper output stream, bound to the top level
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast,
  input logic       m_tvalid,
  input logic       m_tready
);

  // a stalled transaction keeps its valid
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  // a stalled transaction keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("output payload changed while stalled");

  // an error result never carries a byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == 8'h00)
    else $error("error result carries a byte");

  // a result without byte and without error only closes a discarded string
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tlast && m_tdata == 8'h00)
    else $error("empty result that does not end a string");

endmodule

bind json_string_unescaper_unit jsu_checker u_jsu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

[test/tb.sv]
// testbench for the json string unescaper: directed table, random strings, scoreboard
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;

  localparam int unsigned LIMIT        = 300000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned RANDOM_BYTES = 292;
  localparam int unsigned N_DIRECTED   = 28;

  // decoded values of the single-character escapes, and hex digit and letter bytes
  localparam logic [7:0] DEC_LF = 8'h0a;
  localparam logic [7:0] DEC_TAB = 8'h09;
  localparam logic [7:0] DEC_CR = 8'h0d;
  localparam logic [7:0] DEC_BS = 8'h08;
  localparam logic [7:0] DEC_FF = 8'h0c;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_LOW_A = 8'h61;
  localparam logic [7:0] CHR_UP_A = 8'h41;
  localparam logic [7:0] CHR_UP_F = 8'h46;
  localparam logic [7:0][7:0] ESC_SET = {CHR_QUOTE, CHR_BACKSLASH, CHR_SLASH, CHR_N,
                                          CHR_T, CHR_R, CHR_B, CHR_F};

  // one output transaction: {out_byte, byte_valid, out_last, error}
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       err;
  } res_t;

  // one input transaction, optionally with its result written out in the table
  typedef struct packed {
    logic [7:0] data;
    logic       lst;
    logic       typed;
    res_t       want;
  } stim_t;

  localparam res_t NO_WANT = '0;

  logic       clk = 1'b0;
  logic       rst;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic       m_tvalid;
  logic       m_tready;

  // decoder state of the predictor
  mode_t       pmode;
  logic [11:0] accum;

  res_t        decoded_q [$];
  stim_t       cur_stim;
  bit          hold_req = 1'b0;
  int          mismatches = 0;
  int          bytes_in = 0;
  int          results_out = 0;
  int          error_results = 0;
  int          u_escapes = 0;
  int          random_bytes = 0;
  int unsigned cycles = 0;

  // directed table: extremes, escapes, utf-8 boundaries, error paths
  stim_t directed_rows [N_DIRECTED] = '{
    {CHR_UP_A,      1'b0, 1'b1, CHR_UP_A, 1'b1, 1'b0, 1'b0},
    {8'h00,         1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0},
    {8'hff,         1'b1, 1'b1, 8'hff, 1'b1, 1'b1, 1'b0},
    {CHR_BACKSLASH, 1'b0, 1'b0, NO_WANT},
    {CHR_N,         1'b1, 1'b1, DEC_LF, 1'b1, 1'b1, 1'b0},
    // \u07ff, top of the two-byte range
    {CHR_BACKSLASH, 1'b0, 1'b0, NO_WANT},
    {CHR_U,         1'b0, 1'b0, NO_WANT},
    {8'h30,         1'b0, 1'b0, NO_WANT},
    {8'h37,         1'b0, 1'b0, NO_WANT},
    {8'h66,         1'b0, 1'b0, NO_WANT},
    {8'h66,         1'b1, 1'b0, NO_WANT},
    // \ud800, a surrogate encoded as three bytes
    {CHR_BACKSLASH, 1'b0, 1'b0, NO_WANT},
    {CHR_U,         1'b0, 1'b0, NO_WANT},
    {8'h64,         1'b0, 1'b0, NO_WANT},
    {8'h38,         1'b0, 1'b0, NO_WANT},
    {8'h30,         1'b0, 1'b0, NO_WANT},
    {8'h30,         1'b0, 1'b0, NO_WANT},
    // unknown escape, then discard up to the end of the string
    {CHR_BACKSLASH, 1'b0, 1'b0, NO_WANT},
    {8'h78,         1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1},
    {8'h7a,         1'b0, 1'b0, NO_WANT},
    {8'h71,         1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
    // uppercase hex digit on the final byte
    {CHR_BACKSLASH, 1'b0, 1'b0, NO_WANT},
    {CHR_U,         1'b0, 1'b0, NO_WANT},
    {CHR_UP_F,      1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
    // string ends right after a backslash
    {CHR_BACKSLASH, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
    // string ends inside the hex digits
    {CHR_BACKSLASH, 1'b0, 1'b0, NO_WANT},
    {CHR_U,         1'b0, 1'b0, NO_WANT},
    {8'h30,         1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1}
  };

  json_string_unescaper_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // lowercase hex digit value, -1 for anything else
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CHR_ZERO && c <= CHR_ZERO + 8'd9) return int'(c - CHR_ZERO);
    if (c >= CHR_LOW_A && c <= CHR_LOW_A + 8'd5) return int'(c - CHR_LOW_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? CHR_ZERO + 8'(d) : CHR_LOW_A + 8'(d) - 8'd10;
  endfunction

  function automatic void push_result(input logic [7:0] data, input logic valid,
                                      input logic lst, input logic err);
    res_t r;
    r.data = data;
    r.valid = valid;
    r.last = lst;
    r.err = err;
    decoded_q = {decoded_q, r};
  endfunction

  // error result; the rest of a non-final string is dropped
  function automatic void flag_error(input logic lst);
    push_result(8'h00, 1'b0, lst, 1'b1);
    pmode = lst ? MODE_NORMAL : MODE_DISCARD;
    accum = '0;
  endfunction

  // predicts the output transactions caused by one accepted input byte
  function automatic void unescape_byte(input logic [7:0] b, input logic lst);
    int          d;
    logic [15:0] cp;
    case (pmode)
      MODE_NORMAL: begin
        if (b == CHR_BACKSLASH) begin
          if (lst) flag_error(1'b1);
          else pmode = MODE_ESCAPE;
        end else begin
          push_result(b, 1'b1, lst, 1'b0);
        end
      end
      MODE_ESCAPE: begin
        pmode = MODE_NORMAL;
        case (b)
          CHR_QUOTE, CHR_BACKSLASH, CHR_SLASH: push_result(b, 1'b1, lst, 1'b0);
          CHR_N: push_result(DEC_LF, 1'b1, lst, 1'b0);
          CHR_T: push_result(DEC_TAB, 1'b1, lst, 1'b0);
          CHR_R: push_result(DEC_CR, 1'b1, lst, 1'b0);
          CHR_B: push_result(DEC_BS, 1'b1, lst, 1'b0);
          CHR_F: push_result(DEC_FF, 1'b1, lst, 1'b0);
          CHR_U: begin
            if (lst) begin
              flag_error(1'b1);
            end else begin
              pmode = MODE_HEX1;
              accum = '0;
            end
          end
          default: flag_error(lst);
        endcase
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        d = nibble_of(b);
        if (d < 0) begin
          flag_error(lst);
        end else if (lst) begin
          flag_error(1'b1);
        end else begin
          accum = {accum[7:0], 4'(d)};
          pmode = mode_t'(pmode + 3'd1);
        end
      end
      MODE_HEX4: begin
        d = nibble_of(b);
        if (d < 0) begin
          flag_error(lst);
        end else begin
          cp = {accum, 4'(d)};
          pmode = MODE_NORMAL;
          accum = '0;
          u_escapes++;
          // utf-8 encoding of one to three bytes
          if (cp < ONE_BYTE_LIMIT) begin
            push_result(cp[7:0], 1'b1, lst, 1'b0);
          end else if (cp < TWO_BYTE_LIMIT) begin
            push_result({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0);
            push_result({2'b10, cp[5:0]}, 1'b1, lst, 1'b0);
          end else begin
            push_result({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0);
            push_result({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
            push_result({2'b10, cp[5:0]}, 1'b1, lst, 1'b0);
          end
        end
      end
      default: begin
        // discarding: only the final byte closes the string, without error
        if (lst) begin
          pmode = MODE_NORMAL;
          accum = '0;
          push_result(8'h00, 1'b0, 1'b1, 1'b0);
        end
      end
    endcase
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", field, want, got);
      mismatches++;
    end
  endtask

  // offers one transaction after a random gap and waits for its acceptance
  task automatic offer(input stim_t item, input bit dense);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (dense || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_stim = item;
    s_tdata <= item.data;
    s_tlast <= item.lst;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // builds one random string, mostly well-formed escapes, and sends it
  task automatic send_string();
    logic [7:0]  body [$];
    logic [7:0]  bad;
    logic [15:0] cp;
    stim_t       item;
    int          ntok;
    int          kind;
    int          k;
    bit          dense;
    bit          cut;
    dense = ($urandom_range(0, 3) == 0);
    cut = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes with frequent backslashes
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 2) == 0) body = {body, CHR_BACKSLASH};
        else body = {body, 8'($urandom_range(0, 255))};
      end
    end else begin
      ntok = $urandom_range(1, 8);
      for (int t = 0; t < ntok && !cut; t++) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          body = {body, 8'($urandom_range(0, 255))};
        end else if (kind < 65) begin
          body = {body, CHR_BACKSLASH};
          body = {body, ESC_SET[$urandom_range(0, 7)]};
        end else if (kind < 90) begin
          case ($urandom_range(0, 2))
            0: cp = 16'($urandom_range(0, 16'h007f));
            1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
            default: cp = 16'($urandom_range(16'h0800, 16'hffff));
          endcase
          body = {body, CHR_BACKSLASH};
          body = {body, CHR_U};
          for (int j = 3; j >= 0; j--) body = {body, hex_char(cp[4*j +: 4])};
        end else begin
          // broken escapes
          k = $urandom_range(0, 3);
          body = {body, CHR_BACKSLASH};
          case ($urandom_range(0, 2))
            0: body = {body, 8'($urandom_range(0, 255))};
            1: begin
              body = {body, CHR_U};
              repeat (k) body = {body, hex_char(4'($urandom_range(0, 15)))};
              if ($urandom_range(0, 1)) begin
                bad = 8'($urandom_range(CHR_UP_A, CHR_UP_F));
              end else begin
                do bad = 8'($urandom_range(0, 255)); while (nibble_of(bad) >= 0);
              end
              body = {body, bad};
            end
            default: begin
              // truncated escape closes the string
              cut = 1'b1;
              if ($urandom_range(0, 1)) begin
                body = {body, CHR_U};
                repeat (k) body = {body, hex_char(4'($urandom_range(0, 15)))};
              end
            end
          endcase
        end
      end
    end
    for (int i = 0; i < body.size(); i++) begin
      item = '0;
      item.data = body[i];
      item.lst = (i == body.size() - 1);
      offer(item, dense);
    end
    random_bytes += body.size();
  endtask

  // input side: predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      bytes_in++;
      unescape_byte(cur_stim.data, cur_stim.lst);
      if (cur_stim.typed) begin
        // table value stands in for the single predicted result
        decoded_q[decoded_q.size() - 1] = cur_stim.want;
      end
    end
  end

  // output side: compare against the oldest expected transaction
  always @(posedge clk) begin : out_check
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_out++;
      if (m_tuser[1]) error_results++;
      if (decoded_q.size() == 0) begin
        $error("unexpected output transaction: out_byte %h", m_tdata);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.data, m_tdata);
        check_field("byte_valid", 8'(want.valid), 8'(m_tuser[0]));
        check_field("out_last", 8'(want.last), 8'(m_tlast));
        check_field("error", 8'(want.err), 8'(m_tuser[1]));
      end
    end
  end

  // receiver pacing, with one long hold-off on request
  initial begin : sink_pacing
    int stall;
    int r;
    m_tready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 50) stall = 0;
      else if (r < 90) stall = $urandom_range(1, 3);
      else stall = $urandom_range(10, 40);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    cur_stim = '0;
    pmode = MODE_NORMAL;
    accum = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) offer(directed_rows[i], 1'b0);

    // long receiver hold-off while strings keep coming
    hold_req = 1'b1;
    while (random_bytes < RANDOM_BYTES) send_string();
    s_tvalid <= 1'b0;

    // drain, then give the pipeline time to show anything extra
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $error("%0d expected output transactions never arrived", decoded_q.size());
      mismatches++;
    end

    $display("run: %0d input bytes, %0d output transactions, %0d error results",
             bytes_in, results_out, error_results);
    $display("run: %0d unicode escapes decoded, %0d mismatches", u_escapes, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
